[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of the matrix inverse core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held
`define MI3_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds through reset
`define MI3_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse core: default element format,
// epsilon register width and the operand pairs of the 2x2 cofactor products.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int EPS_WIDTH      = 16;
    localparam int N_ELEM         = 9;
    localparam int N_PROD         = 2 * N_ELEM;

    // Adjugate entry k is PROD(2k) - PROD(2k+1); elements indexed row by row from 0
    localparam int MUL_L [N_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int MUL_R [N_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    // Cofactors multiplied by the first row to expand the determinant
    localparam int DET_COF [3] = '{0, 3, 6};

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[rtl/core/matrix_inverse_3x3_unit.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit
// 3x3 fixed-point matrix inverse by the adjugate, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one matrix per request, nine elements row by row, a11 in
//   the lowest bits. m_axis returns the inverse in the same packing, with
//   tuser set when |det| is at or below the epsilon register; the input
//   matrix is then echoed unchanged.
//   i_cfg_we/i_cfg_wdata write the epsilon (Q format of the elements); it
//   resets to one LSB and should only change while the pipeline is empty.
// Throughput: one matrix per cycle, no gaps between requests, while m_axis is not stalled.
// Pipeline: products, cofactors, determinant partials, determinant and the
//   singular test, then the bit-per-stage divider lanes, one per output
//   element, and the output register.
// Reset: synchronous; all valid bits clear and the epsilon returns to one LSB.
// Stall: the whole pipeline holds while a result waits on m_axis_tready;
//   s_axis_tready falls in the same cycle, so no request is lost.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int TDATA_W   = ((N_ELEM * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [EPS_WIDTH-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // a11,a12,a13,a21,..,a33 from bit 0
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // b11,b12,b13,b21,..,b33 from bit 0
    output logic                 m_axis_tuser    // singular
);

    localparam int W     = DATA_WIDTH;
    localparam int PW    = 2 * W;
    localparam int AW    = 2 * W + 1;
    localparam int LOW   = W + 1;
    localparam int DW    = 3 * W + 3;
    localparam int SH    = 2 * FRAC_BITS;
    localparam int CW    = imax(DW, EPS_WIDTH + SH);
    localparam int L     = W + 7;
    localparam int MAT_W = N_ELEM * W;

    logic                  w_en;
    logic signed [W-1:0]   w_a [N_ELEM];
    logic signed [W-1:0]   w_row [3];

    logic [EPS_WIDTH-1:0]  r_eps;
    logic [L-1:0]          r_v;
    logic [MAT_W-1:0]      r_mat [0:L-1];
    logic                  r_sing_d [4:L-1];

    logic signed [PW-1:0]  r_prod [N_PROD];
    logic signed [AW-1:0]  r_adj  [N_ELEM];
    logic signed [AW-1:0]  r_adj2 [N_ELEM];
    logic signed [AW-1:0]  r_adj3 [N_ELEM];
    logic signed [AW-1:0]  r_adj4 [N_ELEM];
    logic signed [PW+1:0]  r_plo  [3];
    logic signed [PW-1:0]  r_phi  [3];
    logic signed [DW-1:0]  r_det;
    logic signed [DW-1:0]  n_det;
    logic        [DW-1:0]  n_dmag;
    logic        [DW-1:0]  r_dmag;
    logic                  r_dneg;
    logic                  n_sing;

    logic signed [W-1:0]   w_q [N_ELEM];
    logic [MAT_W-1:0]      w_res;

    // Advance the pipeline unless a finished result is held
    assign w_en          = ~r_v[L-1] | m_axis_tready;
    assign s_axis_tready = w_en;

    // Unpack the request and pick the first row from the second stage
    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            w_a[k] = $signed(s_axis_tdata[k*W +: W]);
        end
        for (int j = 0; j < 3; j++) begin
            w_row[j] = $signed(r_mat[1][j*W +: W]);
        end
    end

    // Epsilon register and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_WIDTH'(1);
            r_v   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            if (w_en) begin
                r_v <= {r_v[L-2:0], s_axis_tvalid};
            end
        end
    end

    // Sum the split determinant products; take magnitude and singular test
    always_comb begin
        n_det = '0;
        for (int j = 0; j < 3; j++) begin
            n_det = n_det + (DW'(r_phi[j]) <<< LOW) + DW'(r_plo[j]);
        end
        n_dmag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        n_sing = (CW'(n_dmag) <= (CW'(r_eps) << SH));
    end

    // Datapath stages: products, cofactors, det partials, det, magnitude
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_PROD; k++) begin
                r_prod[k] <= w_a[MUL_L[k]] * w_a[MUL_R[k]];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                r_adj[k]  <= AW'(r_prod[2*k]) - AW'(r_prod[2*k+1]);
                r_adj2[k] <= r_adj[k];
                r_adj3[k] <= r_adj2[k];
                r_adj4[k] <= r_adj3[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_plo[j] <= w_row[j] * $signed({1'b0, r_adj[DET_COF[j]][W:0]});
                r_phi[j] <= w_row[j] * $signed(r_adj[DET_COF[j]][AW-1:LOW]);
            end
            r_det  <= n_det;
            r_dmag <= n_dmag;
            r_dneg <= r_det[DW-1];

            // Carry the original matrix and the singular flag alongside
            r_mat[0] <= s_axis_tdata[MAT_W-1:0];
            for (int i = 1; i < L; i++) begin
                r_mat[i] <= r_mat[i-1];
            end
            r_sing_d[4] <= n_sing;
            for (int i = 5; i < L; i++) begin
                r_sing_d[i] <= r_sing_d[i-1];
            end
        end
    end

    // One divider lane per adjugate entry
    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        mi3_div_lane #(
            .W  (W),
            .AW (AW),
            .DW (DW),
            .SH (SH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_adj     (r_adj4[k]),
            .i_det_mag (r_dmag),
            .i_det_neg (r_dneg),
            .o_q       (w_q[k])
        );
    end

    // Select the echo or the quotient for the result
    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            w_res[k*W +: W] = r_sing_d[L-1] ? r_mat[L-1][k*W +: W] : w_q[k];
        end
    end

    assign m_axis_tvalid = r_v[L-1];
    assign m_axis_tdata  = TDATA_W'(w_res);
    assign m_axis_tuser  = r_sing_d[L-1];

endmodule

[rtl/core/mi3_div_lane.sv]
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider for one adjugate entry: one quotient bit per
// stage, truncation toward zero and saturation to the element range.
// ----------------------------------------------------------------------------
module mi3_div_lane
    import mi3_pkg::*;
#(
    parameter int W  = DATA_WIDTH_DEF,
    parameter int AW = 2 * DATA_WIDTH_DEF + 1,
    parameter int DW = 3 * DATA_WIDTH_DEF + 3,
    parameter int SH = 2 * FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_adj,
    input  logic        [DW-1:0] i_det_mag,
    input  logic                 i_det_neg,
    output logic signed [W-1:0]  o_q
);

    localparam int NW = AW + SH;
    localparam int TW = NW - W;
    localparam int RW = imax(DW, TW) + 1;

    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINP = {1'b1, {(W-1){1'b0}}};

    logic [AW-1:0] n_mag;
    logic [NW-1:0] n_num;
    logic [RW-1:0] n_top;

    logic [RW-1:0] r_rem [0:W];
    logic [W-1:0]  r_low [0:W];
    logic [W-1:0]  r_qt  [0:W];
    logic [RW-1:0] r_d   [0:W];
    logic          r_ovf [0:W];
    logic          r_neg [0:W];

    logic [RW-1:0] n_shift [1:W];
    logic          n_ge    [1:W];

    logic [W-1:0]  w_q;
    logic          w_pos_sat;
    logic          w_neg_sat;
    logic [W-1:0]  r_out;

    // Scale the magnitude by 2^(2F); the top part seeds the remainder
    assign n_mag = i_adj[AW-1] ? AW'(-i_adj) : AW'(i_adj);
    assign n_num = {n_mag, {SH{1'b0}}};
    assign n_top = RW'(n_num[NW-1:W]);

    // Trial subtract for every stage
    always_comb begin
        for (int j = 1; j <= W; j++) begin
            n_shift[j] = {r_rem[j-1][RW-2:0], r_low[j-1][W-1]};
            n_ge[j]    = (n_shift[j] >= r_d[j-1]);
        end
    end

    // Advance the quotient stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_top;
            r_low[0] <= n_num[W-1:0];
            r_qt[0]  <= '0;
            r_d[0]   <= RW'(i_det_mag);
            r_ovf[0] <= (n_top >= RW'(i_det_mag));
            r_neg[0] <= i_adj[AW-1] ^ i_det_neg;
            for (int j = 1; j <= W; j++) begin
                r_rem[j] <= n_ge[j] ? (n_shift[j] - r_d[j-1]) : n_shift[j];
                r_low[j] <= {r_low[j-1][W-2:0], 1'b0};
                r_qt[j]  <= {r_qt[j-1][W-2:0], n_ge[j]};
                r_d[j]   <= r_d[j-1];
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
            r_out <= r_neg[W] ? (w_neg_sat ? MINP : (-w_q)) : (w_pos_sat ? MAXP : w_q);
        end
    end

    // Apply the sign and clamp to the element range
    assign w_q       = r_qt[W];
    assign w_pos_sat = r_ovf[W] | w_q[W-1];
    assign w_neg_sat = r_ovf[W] | (w_q[W-1] & (|w_q[W-2:0]));

    assign o_q = $signed(r_out);

endmodule

[rtl/core/mi3_checker.sv]
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the matrix inverse core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mi3_checker
    import mi3_pkg::*;
#(
    parameter int TDATA_W = N_ELEM * DATA_WIDTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    // Input side stalls exactly when a held result blocks the pipeline
    `MI3_ASSERT_RST(a_ready_follows_out, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")

    // A stalled result holds its payload
    `MI3_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // Reset empties the pipeline
    `MI3_ASSERT(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

    // A refused request keeps the held result valid on the output side
    `MI3_ASSERT_RST(a_stall_freeze, i_clk, i_rst_n, s_axis_tvalid && !s_axis_tready |=> m_axis_tvalid, "output emptied while input was refused")

endmodule

bind matrix_inverse_3x3_unit mi3_checker #(
    .TDATA_W (TDATA_W)
) u_mi3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
